// ===== hw/rtl/neighbor_table_with_aging_assert.svh =====
// Assertion macros for the neighbor table checker.
// Needs nothing else; included by the checker file.
`ifndef NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define NTA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("neighbor table assertion failed");

// Next-cycle implication, disabled while in reset.
`define NTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("neighbor table assertion failed");

`endif

// ===== hw/rtl/nta_pkg.sv =====
// Shared types, constants and helpers for the neighbor table with aging.
// Used by nta_cell, the top level and the checker; depends on nothing.
package nta_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TIME_W = 32;
	localparam int ADDR_W = 48;
	localparam int SLOT_W = 3;
	localparam int CNT_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] LIVE_MAX = (TABLE_ENTRIES > 15) ? 4'd15 : CNT_W'(TABLE_ENTRIES);

	localparam logic KIND_DETECT = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BLE_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BCAST_INTERVAL = 2'd2;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;
	localparam logic [TIME_W-1:0] BCAST_INTERVAL_RESET = 32'd5000;

	typedef struct packed {
		logic kind;
		logic [TIME_W-1:0] now_ms;
		logic [ADDR_W-1:0] peer_address;
		logic signed [7:0] signal_strength;
		logic [7:0] peer_mood;
	} request_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_used;
		logic is_new;
		logic refreshed;
		logic dropped;
		logic [CNT_W-1:0] live_count;
		logic broadcast_due;
	} result_t;

	// Token walking the row of cells: search pass first, then apply pass.
	typedef struct packed {
		logic vld;
		logic apply;
		logic kind;
		logic [TIME_W-1:0] now_ms;
		logic [ADDR_W-1:0] peer_address;
		logic signed [7:0] signal_strength;
		logic [7:0] peer_mood;
		logic [IDX_W-1:0] pos;
		logic hit;
		logic [IDX_W-1:0] hit_idx;
		logic free;
		logic [IDX_W-1:0] free_idx;
		logic wr;
		logic [IDX_W-1:0] wr_idx;
		logic clr;
		logic [CNT_W-1:0] live;
	} token_t;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		return SLOT_W'(idx);
	endfunction

endpackage

// ===== hw/rtl/nta_cell.sv =====
// One table entry of the neighbor table plus its stage of the token row.
// Depends on nta_pkg.
module nta_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [nta_pkg::TIME_W-1:0]   timeout_ms,
	input  nta_pkg::token_t              tok_in,
	output nta_pkg::token_t              tok_out
);

	logic [nta_pkg::TIME_W-1:0] last_seen_q;
	logic [nta_pkg::ADDR_W-1:0] address_q;
	logic [7:0]                 strength_q;
	logic [7:0]                 mood_q;
	nta_pkg::token_t            tok_q;

	nta_pkg::token_t            tok_d;
	logic [nta_pkg::TIME_W-1:0] last_seen_d;
	logic [nta_pkg::TIME_W-1:0] age;
	logic [nta_pkg::TIME_W-1:0] stamp;
	logic                       valid;
	logic                       stale;
	logic                       match;
	logic                       target;
	logic                       wr_en;
	logic                       live_here;

	always_comb begin
		valid = last_seen_q != '0;
		age = tok_in.now_ms - last_seen_q;
		stale = age > timeout_ms;
		match = valid && (address_q == tok_in.peer_address);
		target = tok_in.wr && (tok_in.wr_idx == tok_in.pos);
		stamp = (tok_in.now_ms == '0) ? nta_pkg::TIME_W'(1) : tok_in.now_ms;

		tok_d = tok_in;
		tok_d.pos = tok_in.pos + nta_pkg::IDX_W'(1);
		last_seen_d = last_seen_q;
		wr_en = 1'b0;
		live_here = 1'b0;

		if (tok_in.vld) begin
			if (!tok_in.apply) begin
				// search: first valid match, first empty or timed-out slot
				if (!tok_in.hit && match) begin
					tok_d.hit = 1'b1;
					tok_d.hit_idx = tok_in.pos;
				end
				if (!tok_in.free && (!valid || stale)) begin
					tok_d.free = 1'b1;
					tok_d.free_idx = tok_in.pos;
				end
			end else begin
				if (target) begin
					last_seen_d = stamp;
					wr_en = 1'b1;
					// age of the fresh stamp is zero, or all ones when time is zero
					live_here = (tok_in.now_ms != '0) || (timeout_ms == '1);
				end else if (tok_in.clr && valid && stale) begin
					last_seen_d = '0;
				end else begin
					live_here = valid && !stale;
				end
				if (live_here && (tok_in.live != '1)) begin
					tok_d.live = tok_in.live + nta_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			last_seen_q <= '0;
		end else begin
			tok_q <= tok_d;
			last_seen_q <= last_seen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			address_q <= tok_in.peer_address;
			strength_q <= tok_in.signal_strength;
			mood_q <= tok_in.peer_mood;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/neighbor_table_with_aging.sv =====
// Top level of the neighbor table with aging: control and the row of cells.
// Depends on nta_pkg and nta_cell.
//
//  channel   signals                        direction  handshake
//  request   start, busy, request           in         start & !busy
//  result    done, result                   out        done, one cycle, no stall
//  config    cfg_valid, cfg_ready,          in         cfg_valid & cfg_ready
//            cfg_index, cfg_data
//
// A request walks the row of TABLE_ENTRIES cells twice, one cell per cycle: a
// search pass for match and free slot, then an apply pass that writes, ages and counts.
// The result strobes once the apply pass leaves the last cell; busy drops in the
// strobe cycle, so a new request is taken only after the last one is done.
// Reset empties every entry at once; no clearing pass. The result side cannot stall.
module neighbor_table_with_aging (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  nta_pkg::request_t               request,
	output logic                            done,
	output nta_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nta_pkg::TIME_W-1:0]      cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY
	} state_t;

	state_t                      state_q;
	nta_pkg::token_t             launch_q;
	nta_pkg::result_t            res_q;
	logic                        done_q;
	logic [nta_pkg::TIME_W-1:0]  last_bcast_q;
	logic                        ble_enabled_q;
	logic [nta_pkg::TIME_W-1:0]  timeout_q;
	logic [nta_pkg::TIME_W-1:0]  interval_q;

	nta_pkg::token_t             tok [nta_pkg::TABLE_ENTRIES+1];
	nta_pkg::token_t             tail;
	nta_pkg::token_t             fresh_tok;
	nta_pkg::token_t             apply_tok;
	logic [nta_pkg::TIME_W-1:0]  bcast_age;
	logic                        bcast_due;
	logic                        is_detect;

	assign tok[0] = launch_q;
	assign tail = tok[nta_pkg::TABLE_ENTRIES];

	for (genvar i = 0; i < nta_pkg::TABLE_ENTRIES; i++) begin : g_cell
		nta_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.timeout_ms (timeout_q),
			.tok_in     (tok[i]),
			.tok_out    (tok[i+1])
		);
	end

	assign busy = state_q != ST_IDLE;
	assign cfg_ready = !busy;
	assign done = done_q;
	assign result = res_q;

	always_comb begin
		is_detect = tail.kind == nta_pkg::KIND_DETECT;
		bcast_age = tail.now_ms - last_bcast_q;
		bcast_due = !is_detect && ble_enabled_q && (bcast_age > interval_q);

		fresh_tok = '0;
		fresh_tok.vld = 1'b1;
		fresh_tok.kind = request.kind;
		fresh_tok.now_ms = request.now_ms;
		fresh_tok.peer_address = request.peer_address;
		fresh_tok.signal_strength = request.signal_strength;
		fresh_tok.peer_mood = request.peer_mood;

		// turn the search outcome into write / clear orders for the apply pass
		apply_tok = tail;
		apply_tok.apply = 1'b1;
		apply_tok.pos = '0;
		apply_tok.live = '0;
		apply_tok.wr = is_detect && (tail.hit || tail.free);
		apply_tok.wr_idx = tail.hit ? tail.hit_idx : tail.free_idx;
		apply_tok.clr = !is_detect && ble_enabled_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			launch_q <= '0;
			res_q <= '0;
			done_q <= 1'b0;
			last_bcast_q <= '0;
		end else begin
			launch_q.vld <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						launch_q <= fresh_tok;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (tail.vld) begin
						launch_q <= apply_tok;
						res_q <= '0;
						if (is_detect) begin
							res_q.refreshed <= tail.hit;
							res_q.is_new <= !tail.hit && tail.free;
							res_q.dropped <= !tail.hit && !tail.free;
							if (tail.hit || tail.free) begin
								res_q.slot_used <= nta_pkg::to_slot(apply_tok.wr_idx);
							end
						end else begin
							res_q.broadcast_due <= bcast_due;
						end
						if (bcast_due) begin
							last_bcast_q <= tail.now_ms;
						end
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (tail.vld) begin
						res_q.live_count <= tail.live;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ble_enabled_q <= 1'b0;
			timeout_q <= nta_pkg::TIMEOUT_RESET;
			interval_q <= nta_pkg::BCAST_INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nta_pkg::REG_BLE_ENABLED: ble_enabled_q <= cfg_data[0];
				nta_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				nta_pkg::REG_BCAST_INTERVAL: interval_q <= cfg_data;
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/nta_checker.sv =====
// Port-level checks for the neighbor table with aging, bound to the top level.
// Depends on nta_pkg and neighbor_table_with_aging_assert.svh.
`include "neighbor_table_with_aging_assert.svh"

module nta_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             done,
	input  nta_pkg::result_t result
);

	logic [3:0] outcome_flags;
	logic       slot_taken;

	assign outcome_flags = {result.is_new, result.refreshed, result.dropped,
		result.broadcast_due};
	assign slot_taken = result.is_new || result.refreshed;

	`NTA_ASSERT_NEXT(chk_accept_busy, clk, arst_n, start && !busy, busy)
	`NTA_ASSERT_NEXT(chk_done_pulse, clk, arst_n, done, !done)
	`NTA_ASSERT_IMPL(chk_one_outcome, clk, arst_n, done, $countones(outcome_flags) <= 1)
	`NTA_ASSERT_IMPL(chk_slot_zero, clk, arst_n, done && !slot_taken, result.slot_used == '0)
	`NTA_ASSERT_IMPL(chk_live_max, clk, arst_n, done, result.live_count <= nta_pkg::LIVE_MAX)

endmodule

bind neighbor_table_with_aging nta_checker u_nta_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
